// ----- rtl/core/bpa_pkg.sv -----
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants of the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

	localparam int MAX_PAGES_DEF = 65536;
	localparam int WORD_BITS     = 8;
	localparam int WORD_SHIFT    = 3;
	localparam int FRAME_W       = 40;
	localparam int COUNT_W       = 17;
	localparam int CFG_DATA_W    = 64;
	localparam int CFG_ADDR_W    = 4;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_ZERO     = 2'd1;
	localparam logic [1:0] STATUS_NOMEM    = 2'd2;
	localparam logic [1:0] STATUS_BAD_ADDR = 2'd3;

	localparam logic REG_BASE     = 1'b0;
	localparam logic REG_CAPACITY = 1'b1;

	localparam logic [COUNT_W-1:0] CAPACITY_RESET = 17'd65536;

	typedef struct packed {
		logic               operation;
		logic [COUNT_W-1:0] num_pages;
		logic [FRAME_W-1:0] frame_number;
	} req_t;

	typedef struct packed {
		logic [FRAME_W-1:0] result_frame;
		logic [1:0]         status;
		logic [COUNT_W-1:0] free_pages;
	} rsp_t;

endpackage

// ----- rtl/core/bitmap_page_allocator_core.sv -----
// ----------------------------------------------------------------------------
// bitmap_page_allocator_core
// Next-fit contiguous page allocator over a bitmap held in one memory.
// ----------------------------------------------------------------------------
//  channel  | signals                          | direction
//  ---------+----------------------------------+----------
//  request  | req_valid, req_stall, req        | in
//  response | rsp_valid, rsp_stall, rsp        | out
//  config   | psel penable pwrite paddr pwdata | in/out
//
// The bitmap sits in a memory of 8-bit words, one read or write per cycle.
// An allocate scans one word a cycle from the cursor, then marks the run by
// reading and writing each word touched in turn; a free reads and writes each
// word touched. Every request ends with a response load and a return to idle.
// After reset and after a capacity write a clearing pass over every memory
// word runs with req_stall high; req_stall is also high during a register
// write. One request is in flight at a time;
// a finished response waits in the output register while the next is taken.
module bitmap_page_allocator_core #(
	parameter int MAX_PAGES = bpa_pkg::MAX_PAGES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  bpa_pkg::req_t                   req,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output bpa_pkg::rsp_t                   rsp,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [bpa_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [bpa_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [bpa_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                            pready
);

	localparam int PC_W  = $clog2(MAX_PAGES + 1);
	localparam int CW    = (PC_W > bpa_pkg::COUNT_W) ? PC_W : bpa_pkg::COUNT_W;
	localparam int DEPTH = (MAX_PAGES + bpa_pkg::WORD_BITS - 1) / bpa_pkg::WORD_BITS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FW    = bpa_pkg::FRAME_W;
	localparam int NW    = bpa_pkg::COUNT_W;
	localparam int WB    = bpa_pkg::WORD_BITS;
	localparam int WS    = bpa_pkg::WORD_SHIFT;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_SEARCH, ST_MRD, ST_MWR, ST_DONE
	} state_t;

	state_t          state_q;
	logic [FW-1:0]   base_q;
	logic [NW-1:0]   cap_q;
	logic [NW-1:0]   avail_q;
	logic [CW-1:0]   cursor_q;
	logic [AW-1:0]   clr_q;
	logic            op_q;
	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   cur_q;
	logic [CW-1:0]   lo_q;
	logic [CW-1:0]   hi_q;
	logic            pass2_q;
	logic [AW:0]     raddr_q;
	logic [AW:0]     lastw_q;
	logic [CW-1:0]   run_q;
	logic [CW-1:0]   first_q;
	logic [FW-1:0]   res_frame_q;
	logic [1:0]      res_status_q;
	logic            rdv_s1;
	logic [AW-1:0]   rda_s1;
	logic [WB-1:0]   rdata_s1;

	logic [WB-1:0]   mem [DEPTH];

	logic [CW-1:0]   cap_eff;
	logic [CW-1:0]   new_cap_eff;
	logic [CW-1:0]   cnt_in;
	logic [CW-1:0]   cur_in;
	logic [FW-1:0]   diff_in;
	logic            bad_addr;
	logic [CW-1:0]   idx_in;
	logic [CW:0]     end_raw;
	logic [CW-1:0]   end_in;
	logic            issue;
	logic [CW-1:0]   word_pos;
	logic [CW-1:0]   next_pos;
	logic            found_c;
	logic [CW-1:0]   run_c;
	logic [CW-1:0]   first_c;
	logic [WB-1:0]   mask_c;
	logic [3:0]      pop_c;
	logic [WB-1:0]   wdata_c;
	logic            we;
	logic [AW-1:0]   waddr;
	logic            cfg_we;
	logic            rsp_load;
	logic [CW-1:0]   st_end;

	assign pready    = 1'b1;
	assign cfg_we    = psel & penable & pwrite;
	assign req_stall = (state_q != ST_IDLE) || cfg_we;
	assign rsp_load  = (state_q == ST_DONE) && !cfg_we && (!rsp_valid || !rsp_stall);
	assign prdata    = (paddr[3] == bpa_pkg::REG_CAPACITY) ? bpa_pkg::CFG_DATA_W'(cap_q)
	                                                       : bpa_pkg::CFG_DATA_W'(base_q);

	assign cap_eff = (CW'(cap_q) > CW'(MAX_PAGES)) ? CW'(MAX_PAGES) : CW'(cap_q);
	assign new_cap_eff = (CW'(pwdata[NW-1:0]) > CW'(MAX_PAGES)) ? CW'(MAX_PAGES)
	                                                            : CW'(pwdata[NW-1:0]);

	assign cnt_in   = CW'(req.num_pages);
	assign cur_in   = (cursor_q >= cap_eff) ? '0 : cursor_q;
	assign diff_in  = req.frame_number - base_q;
	assign bad_addr = (req.frame_number < base_q) || (diff_in >= FW'(cap_eff));
	assign idx_in   = diff_in[CW-1:0];
	assign end_raw  = {1'b0, idx_in} + {1'b0, cnt_in};
	assign end_in   = (end_raw > {1'b0, cap_eff}) ? cap_eff : end_raw[CW-1:0];
	assign st_end   = first_c + cnt_q;

	assign issue    = (state_q == ST_SEARCH) && (raddr_q <= lastw_q);
	assign word_pos = CW'(rda_s1) << WS;
	assign next_pos = (CW'(rda_s1) + CW'(1)) << WS;

	// Run tracking and range mask over the word just read.
	always_comb begin
		logic [CW-1:0] run_v;
		logic [CW-1:0] first_v;
		logic          found_v;
		logic [CW-1:0] pos_v;
		logic          inr_v;
		logic [3:0]    pop_v;
		run_v   = run_q;
		first_v = first_q;
		found_v = 1'b0;
		pop_v   = '0;
		mask_c  = '0;
		for (int j = 0; j < WB; j++) begin
			pos_v = word_pos + CW'(j);
			inr_v = (pos_v >= lo_q) && (pos_v < hi_q);
			mask_c[j] = inr_v;
			if (inr_v && !found_v) begin
				if (rdata_s1[j]) begin
					run_v = '0;
				end else begin
					if (run_v == '0)
						first_v = pos_v;
					run_v = run_v + CW'(1);
					if (run_v == cnt_q)
						found_v = 1'b1;
				end
			end
		end
		for (int j = 0; j < WB; j++) begin
			pop_v = pop_v + 4'(rdata_s1[j] & mask_c[j]);
		end
		run_c   = run_v;
		first_c = first_v;
		found_c = found_v;
		pop_c   = pop_v;
	end

	assign wdata_c = (op_q == bpa_pkg::OP_FREE) ? (rdata_s1 & ~mask_c) : (rdata_s1 | mask_c);
	assign we      = (state_q == ST_CLEAR) || (state_q == ST_MWR);
	assign waddr   = (state_q == ST_CLEAR) ? clr_q : raddr_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= (state_q == ST_CLEAR) ? '0 : wdata_c;
		rdata_s1 <= mem[raddr_q[AW-1:0]];
		rda_s1   <= raddr_q[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			base_q    <= '0;
			cap_q     <= bpa_pkg::CAPACITY_RESET;
			avail_q   <= (CW'(bpa_pkg::CAPACITY_RESET) > CW'(MAX_PAGES)) ? NW'(MAX_PAGES)
			                                                             : bpa_pkg::CAPACITY_RESET;
			cursor_q  <= '0;
			clr_q     <= '0;
			rdv_s1    <= 1'b0;
			rsp_valid <= 1'b0;
		end else begin
			rdv_s1 <= issue;
			if (rsp_load)
				rsp_valid <= 1'b1;
			else if (!rsp_stall)
				rsp_valid <= 1'b0;
			if (cfg_we) begin
				if (paddr[3] == bpa_pkg::REG_BASE) begin
					base_q <= pwdata[FW-1:0];
				end else begin
					cap_q    <= pwdata[NW-1:0];
					avail_q  <= NW'(new_cap_eff);
					cursor_q <= '0;
					clr_q    <= '0;
					state_q  <= ST_CLEAR;
				end
			end else begin
				unique case (state_q)
					ST_CLEAR: begin
						clr_q <= clr_q + AW'(1);
						if (clr_q == AW'(DEPTH - 1))
							state_q <= ST_IDLE;
					end
					ST_IDLE: begin
						if (req_valid) begin
							op_q        <= req.operation;
							cnt_q       <= cnt_in;
							res_frame_q <= '0;
							if (req.operation == bpa_pkg::OP_ALLOC) begin
								if (cnt_in == '0) begin
									res_status_q <= bpa_pkg::STATUS_ZERO;
									state_q      <= ST_DONE;
								end else if (cnt_in > CW'(avail_q) || cnt_in > cap_eff) begin
									res_status_q <= bpa_pkg::STATUS_NOMEM;
									state_q      <= ST_DONE;
								end else begin
									cur_q   <= cur_in;
									lo_q    <= cur_in;
									hi_q    <= cap_eff;
									pass2_q <= 1'b0;
									raddr_q <= (AW+1)'(cur_in >> WS);
									lastw_q <= (AW+1)'((cap_eff - CW'(1)) >> WS);
									run_q   <= '0;
									state_q <= ST_SEARCH;
								end
							end else begin
								if (bad_addr) begin
									res_status_q <= bpa_pkg::STATUS_BAD_ADDR;
									state_q      <= ST_DONE;
								end else begin
									res_status_q <= bpa_pkg::STATUS_OK;
									if (idx_in < cursor_q)
										cursor_q <= idx_in;
									lo_q    <= idx_in;
									hi_q    <= end_in;
									raddr_q <= (AW+1)'(idx_in >> WS);
									lastw_q <= (AW+1)'((end_in - CW'(1)) >> WS);
									state_q <= (end_in == idx_in) ? ST_DONE : ST_MRD;
								end
							end
						end
					end
					ST_SEARCH: begin
						if (rdv_s1 && found_c) begin
							avail_q      <= avail_q - NW'(cnt_q);
							cursor_q     <= (st_end >= cap_eff) ? '0 : st_end;
							res_frame_q  <= base_q + FW'(first_c);
							res_status_q <= bpa_pkg::STATUS_OK;
							lo_q         <= first_c;
							hi_q         <= st_end;
							raddr_q      <= (AW+1)'(first_c >> WS);
							lastw_q      <= (AW+1)'((st_end - CW'(1)) >> WS);
							state_q      <= ST_MRD;
						end else begin
							if (issue)
								raddr_q <= raddr_q + (AW+1)'(1);
							if (rdv_s1) begin
								first_q <= first_c;
								if (next_pos >= hi_q) begin
									if (!pass2_q && cur_q != '0) begin
										pass2_q <= 1'b1;
										lo_q    <= '0;
										hi_q    <= cur_q;
										raddr_q <= '0;
										lastw_q <= (AW+1)'((cur_q - CW'(1)) >> WS);
										run_q   <= '0;
									end else begin
										run_q        <= run_c;
										res_status_q <= bpa_pkg::STATUS_NOMEM;
										state_q      <= ST_DONE;
									end
								end else begin
									run_q <= run_c;
								end
							end
						end
					end
					ST_MRD: begin
						state_q <= ST_MWR;
					end
					ST_MWR: begin
						if (op_q == bpa_pkg::OP_FREE)
							avail_q <= avail_q + NW'(pop_c);
						if (raddr_q == lastw_q) begin
							state_q <= ST_DONE;
						end else begin
							raddr_q <= raddr_q + (AW+1)'(1);
							state_q <= ST_MRD;
						end
					end
					ST_DONE: begin
						if (rsp_load) begin
							rsp.result_frame <= res_frame_q;
							rsp.status       <= res_status_q;
							rsp.free_pages   <= avail_q;
							state_q          <= ST_IDLE;
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

endmodule

// ----- rtl/core/bpa_checker.sv -----
// ----------------------------------------------------------------------------
// bpa_checker
// Port-level checks on the bitmap page allocator, bound to bitmap_page_allocator_core.
// ----------------------------------------------------------------------------
module bpa_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            req_valid,
	input logic                            req_stall,
	input bpa_pkg::req_t                   req,
	input logic                            rsp_valid,
	input logic                            rsp_stall,
	input bpa_pkg::rsp_t                   rsp,
	input logic                            psel,
	input logic                            penable,
	input logic                            pwrite,
	input logic [bpa_pkg::CFG_ADDR_W-1:0]  paddr,
	input logic [bpa_pkg::CFG_DATA_W-1:0]  pwdata,
	input logic [bpa_pkg::CFG_DATA_W-1:0]  prdata,
	input logic                            pready
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response word changed while stalled");

	a_fail_no_frame: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != bpa_pkg::STATUS_OK |-> rsp.result_frame == '0)
		else $error("frame reported on failed request");

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.free_pages <= bpa_pkg::CAPACITY_RESET)
		else $error("free count beyond capacity");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second request taken while one is in flight");

endmodule

bind bitmap_page_allocator_core bpa_checker u_bpa_checker (.*);
